// ===== design/crsdf_pkg.sv =====
// Shared types and constants for the capped surface of revolution distance core.
// Used by crsdf_horner and cubic_revolution_sdf_core; depends on nothing.
package crsdf_pkg;

    localparam int ACC_BITS     = 63;
    localparam int CFG_IDX_BITS = 3;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_COEF_CUBIC  = 3'd0,
        REG_COEF_SQUARE = 3'd1,
        REG_COEF_LINEAR = 3'd2,
        REG_COEF_CONST  = 3'd3,
        REG_Z_LOW       = 3'd4,
        REG_Z_HIGH      = 3'd5,
        REG_INVERT_SIGN = 3'd6
    } cfg_reg_t;

endpackage

// ===== design/crsdf_horner.sv =====
// One Horner step acc*z/2^FRAC_BITS + coef over three register stages, saturated.
// Uses crsdf_pkg for the accumulator width.
module crsdf_horner #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16,
    parameter int SIDE_W    = 1
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic [crsdf_pkg::ACC_BITS-1:0]   acc_in,
    input  logic [WORD_BITS-1:0]             z_in,
    input  logic [WORD_BITS-1:0]             coef,
    input  logic [SIDE_W-1:0]                side_in,
    output logic                             out_valid,
    output logic [crsdf_pkg::ACC_BITS-1:0]   acc_out,
    output logic [WORD_BITS-1:0]             z_out,
    output logic [SIDE_W-1:0]                side_out
);

    localparam int AB = crsdf_pkg::ACC_BITS;
    localparam int HB = AB - WORD_BITS;
    localparam int LW = 2 * WORD_BITS;
    localparam int PW = AB + WORD_BITS;
    localparam int QW = PW - FRAC_BITS;

    logic [AB-1:0]        a_mag;
    logic [WORD_BITS-1:0] z_mag;
    logic [LW-1:0]        plo_next;
    logic [AB-1:0]        phi_next;

    logic                 v0_reg;
    logic [LW-1:0]        plo_reg;
    logic [AB-1:0]        phi_reg;
    logic                 neg0_reg;
    logic [WORD_BITS-1:0] z0_reg;
    logic [SIDE_W-1:0]    side0_reg;

    logic [PW-1:0]        prod_next;

    logic                 v1_reg;
    logic [PW-1:0]        prod_reg;
    logic                 neg_reg;
    logic [WORD_BITS-1:0] z1_reg;
    logic [SIDE_W-1:0]    side1_reg;

    logic [QW-1:0]        q;
    logic                 frac_nz;
    logic                 big;
    logic [AB:0]          pr;
    logic [AB+1:0]        sum;
    logic [AB-1:0]        acc_next;

    logic                 v2_reg;
    logic [AB-1:0]        acc_reg;
    logic [WORD_BITS-1:0] z2_reg;
    logic [SIDE_W-1:0]    side2_reg;

    // split the accumulator magnitude into a low and a high partial product
    always_comb
    begin
        a_mag    = acc_in[AB-1] ? (~acc_in + 1'b1) : acc_in;
        z_mag    = z_in[WORD_BITS-1] ? (~z_in + 1'b1) : z_in;
        plo_next = LW'(a_mag[WORD_BITS-1:0]) * LW'(z_mag);
        phi_next = AB'(a_mag[AB-1:WORD_BITS]) * AB'(z_mag);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        plo_reg   <= plo_next;
        phi_reg   <= phi_next;
        neg0_reg  <= acc_in[AB-1] ^ z_in[WORD_BITS-1];
        z0_reg    <= z_in;
        side0_reg <= side_in;
    end

    always_comb
    begin
        prod_next = (PW'(phi_reg) << WORD_BITS) + PW'(plo_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= prod_next;
        neg_reg   <= neg0_reg;
        z1_reg    <= z0_reg;
        side1_reg <= side0_reg;
    end

    // floor the scaled product, saturate, add the coefficient, saturate again
    always_comb
    begin
        q       = prod_reg[PW-1:FRAC_BITS];
        frac_nz = |prod_reg[FRAC_BITS-1:0];
        big     = |q[QW-1:AB-1];
        if (!neg_reg)
        begin
            pr = big ? {2'b00, {(AB-1){1'b1}}} : {2'b00, q[AB-2:0]};
        end
        else
        begin
            pr = big ? {2'b11, {(AB-1){1'b0}}}
                     : (~{2'b00, q[AB-2:0]} + (AB+1)'(!frac_nz));
        end
        sum = {pr[AB], pr} + {{(AB+2-WORD_BITS){coef[WORD_BITS-1]}}, coef};
        if ((sum[AB+1] == sum[AB]) && (sum[AB] == sum[AB-1]))
        begin
            acc_next = sum[AB-1:0];
        end
        else if (sum[AB+1])
        begin
            acc_next = {1'b1, {(AB-1){1'b0}}};
        end
        else
        begin
            acc_next = {1'b0, {(AB-1){1'b1}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        z2_reg    <= z1_reg;
        side2_reg <= side1_reg;
    end

    assign out_valid = v2_reg;
    assign acc_out   = acc_reg;
    assign z_out     = z2_reg;
    assign side_out  = side2_reg;

endmodule

// ===== design/crsdf_isqrt.sv =====
// Pipelined floor square root, one result bit per register stage.
// Standalone; IN_BITS must be even.
module crsdf_isqrt #(
    parameter int IN_BITS = 98
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [IN_BITS-1:0]   radicand,
    output logic                 out_valid,
    output logic [IN_BITS/2-1:0] root
);

    localparam int OB = IN_BITS / 2;
    localparam int RB = OB + 2;

    logic               v_reg    [1:OB];
    logic [RB-1:0]      rem_reg  [1:OB];
    logic [OB-1:0]      root_reg [1:OB];
    logic [IN_BITS-1:0] rad_reg  [1:OB];

    genvar i;
    for (i = 0; i < OB; i++)
    begin : g_step
        logic               v_cur;
        logic [RB-1:0]      rem_cur;
        logic [OB-1:0]      root_cur;
        logic [IN_BITS-1:0] rad_cur;
        logic [RB-1:0]      r2;
        logic [RB-1:0]      trial;
        logic               fits;

        if (i == 0)
        begin : g_first
            assign v_cur    = in_valid;
            assign rem_cur  = '0;
            assign root_cur = '0;
            assign rad_cur  = radicand;
        end
        else
        begin : g_rest
            assign v_cur    = v_reg[i];
            assign rem_cur  = rem_reg[i];
            assign root_cur = root_reg[i];
            assign rad_cur  = rad_reg[i];
        end

        assign r2    = {rem_cur[OB-1:0], rad_cur[IN_BITS-1 -: 2]};
        assign trial = {root_cur, 2'b01};
        assign fits  = (r2 >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i+1] <= 1'b0;
            end
            else
            begin
                v_reg[i+1] <= v_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[i+1]  <= fits ? (r2 - trial) : r2;
            root_reg[i+1] <= {root_cur[OB-2:0], fits};
            rad_reg[i+1]  <= {rad_cur[IN_BITS-3:0], 2'b00};
        end
    end

    assign out_valid = v_reg[OB];
    assign root      = root_reg[OB];

endmodule

// ===== design/cubic_revolution_sdf_core.sv =====
// Top level of the capped surface of revolution signed distance core.
// Uses crsdf_pkg, crsdf_horner and crsdf_isqrt.
//
// Takes one query point per clock (busy never rises) and returns its signed
// distance with done high for one cycle. A request passes the input register,
// the cubic evaluation in Horner steps, the squaring in the square and sum
// stages, the bit-per-stage square root pipelines (with the default widths
// SQ_IN is 78) and the output register. There is no output
// backpressure: results must be taken in the cycle they appear. Write
// configuration only while no request is in flight.
module cubic_revolution_sdf_core #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [WORD_BITS-1:0]           point_x,
    input  logic signed [WORD_BITS-1:0]           point_y,
    input  logic signed [WORD_BITS-1:0]           point_z,
    output logic                                  done,
    output logic signed [WORD_BITS-1:0]           distance,
    input  logic                                  cfg_we,
    input  logic [crsdf_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [WORD_BITS-1:0]                  cfg_data
);

    localparam int W      = WORD_BITS;
    localparam int AB     = crsdf_pkg::ACC_BITS;
    localparam int PL     = 2 * W;
    localparam int RL     = AB - 1 + FRAC_BITS;
    localparam int SQ_RAW = (PL > RL) ? PL : RL;
    localparam int SQ_IN  = SQ_RAW + (SQ_RAW % 2);
    localparam int SQ_OUT = SQ_IN / 2;
    localparam int SIDE_W = 3 * W + 1;
    localparam int E      = SQ_OUT + 2;

    logic [W-1:0] coef_cubic_reg;
    logic [W-1:0] coef_square_reg;
    logic [W-1:0] coef_linear_reg;
    logic [W-1:0] coef_const_reg;
    logic [W-1:0] z_low_reg;
    logic [W-1:0] z_high_reg;
    logic         invert_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_cubic_reg  <= '0;
            coef_square_reg <= '0;
            coef_linear_reg <= '0;
            coef_const_reg  <= W'(1) << FRAC_BITS;
            z_low_reg       <= ~(W'(1) << FRAC_BITS) + 1'b1;
            z_high_reg      <= W'(1) << FRAC_BITS;
            invert_reg      <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (crsdf_pkg::cfg_reg_t'(cfg_index))
                crsdf_pkg::REG_COEF_CUBIC:  coef_cubic_reg  <= cfg_data;
                crsdf_pkg::REG_COEF_SQUARE: coef_square_reg <= cfg_data;
                crsdf_pkg::REG_COEF_LINEAR: coef_linear_reg <= cfg_data;
                crsdf_pkg::REG_COEF_CONST:  coef_const_reg  <= cfg_data;
                crsdf_pkg::REG_Z_LOW:       z_low_reg       <= cfg_data;
                crsdf_pkg::REG_Z_HIGH:      z_high_reg      <= cfg_data;
                crsdf_pkg::REG_INVERT_SIGN: invert_reg      <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // input stage: slab term against both caps
    logic [W:0] zx, hi_d, lo_d, slab_next;
    logic       in_v_reg;
    logic [W-1:0] x0_reg, y0_reg, z0_reg;
    logic [W:0]   slab0_reg;

    always_comb
    begin
        zx        = {point_z[W-1], point_z};
        hi_d      = zx - {z_high_reg[W-1], z_high_reg};
        lo_d      = {z_low_reg[W-1], z_low_reg} - zx;
        slab_next = ($signed(lo_d) > $signed(hi_d)) ? lo_d : hi_d;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg <= 1'b0;
        end
        else
        begin
            in_v_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        x0_reg    <= point_x;
        y0_reg    <= point_y;
        z0_reg    <= point_z;
        slab0_reg <= slab_next;
    end

    // cubic in Horner form
    logic              h1_v, h2_v, h3_v;
    logic [AB-1:0]     h1_acc, h2_acc, h3_acc;
    logic [W-1:0]      h1_z, h2_z, h3_z;
    logic [SIDE_W-1:0] h1_side, h2_side, h3_side;

    crsdf_horner #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS), .SIDE_W(SIDE_W)) u_horner1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_v_reg),
        .acc_in    ({{(AB-W){coef_cubic_reg[W-1]}}, coef_cubic_reg}),
        .z_in      (z0_reg),
        .coef      (coef_square_reg),
        .side_in   ({x0_reg, y0_reg, slab0_reg}),
        .out_valid (h1_v),
        .acc_out   (h1_acc),
        .z_out     (h1_z),
        .side_out  (h1_side)
    );

    crsdf_horner #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS), .SIDE_W(SIDE_W)) u_horner2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (h1_v),
        .acc_in    (h1_acc),
        .z_in      (h1_z),
        .coef      (coef_linear_reg),
        .side_in   (h1_side),
        .out_valid (h2_v),
        .acc_out   (h2_acc),
        .z_out     (h2_z),
        .side_out  (h2_side)
    );

    crsdf_horner #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS), .SIDE_W(SIDE_W)) u_horner3 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (h2_v),
        .acc_in    (h2_acc),
        .z_in      (h2_z),
        .coef      (coef_const_reg),
        .side_in   (h2_side),
        .out_valid (h3_v),
        .acc_out   (h3_acc),
        .z_out     (h3_z),
        .side_out  (h3_side)
    );

    // square stage: clamp radius squared, square the planar coordinates
    logic [W-1:0]    hx, hy, hx_mag, hy_mag;
    logic            sq_v_reg;
    logic [PL-1:0]   sqx_reg, sqy_reg;
    logic [AB-2:0]   rr_reg;
    logic [W:0]      slab1_reg;

    always_comb
    begin
        hx     = h3_side[SIDE_W-1 -: W];
        hy     = h3_side[SIDE_W-W-1 -: W];
        hx_mag = hx[W-1] ? (~hx + 1'b1) : hx;
        hy_mag = hy[W-1] ? (~hy + 1'b1) : hy;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_v_reg <= 1'b0;
        end
        else
        begin
            sq_v_reg <= h3_v;
        end
    end

    always_ff @(posedge clk)
    begin
        sqx_reg   <= PL'(hx_mag) * PL'(hx_mag);
        sqy_reg   <= PL'(hy_mag) * PL'(hy_mag);
        rr_reg    <= h3_acc[AB-1] ? '0 : h3_acc[AB-2:0];
        slab1_reg <= h3_side[W:0];
    end

    // sum stage: planar radicand and scaled radius radicand
    logic             sum_v_reg;
    logic [SQ_IN-1:0] psum_reg, rrad_reg;
    logic [W:0]       slab2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_v_reg <= 1'b0;
        end
        else
        begin
            sum_v_reg <= sq_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        psum_reg  <= SQ_IN'(sqx_reg) + SQ_IN'(sqy_reg);
        rrad_reg  <= SQ_IN'({rr_reg, {FRAC_BITS{1'b0}}});
        slab2_reg <= slab1_reg;
    end

    logic              pl_valid, rr_valid;
    logic [SQ_OUT-1:0] pl_root, rr_root;

    crsdf_isqrt #(.IN_BITS(SQ_IN)) u_isqrt_planar (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sum_v_reg),
        .radicand  (psum_reg),
        .out_valid (pl_valid),
        .root      (pl_root)
    );

    crsdf_isqrt #(.IN_BITS(SQ_IN)) u_isqrt_radius (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sum_v_reg),
        .radicand  (rrad_reg),
        .out_valid (rr_valid),
        .root      (rr_root)
    );

    // hold the slab term alongside the root pipelines
    logic [W:0] slab_pipe_reg [0:SQ_OUT-1];

    always_ff @(posedge clk)
    begin
        slab_pipe_reg[0] <= slab2_reg;
        for (int k = 1; k < SQ_OUT; k++)
        begin
            slab_pipe_reg[k] <= slab_pipe_reg[k-1];
        end
    end

    // output stage: combine, negate, saturate
    logic signed [E-1:0] radial, slab_e, sd;
    logic [E:0]          sd_s;
    logic [W-1:0]        dist_next;
    logic                done_reg;
    logic [W-1:0]        dist_reg;

    always_comb
    begin
        radial = $signed({2'b00, pl_root}) - $signed({2'b00, rr_root});
        slab_e = $signed({{(E-W-1){slab_pipe_reg[SQ_OUT-1][W]}}, slab_pipe_reg[SQ_OUT-1]});
        sd     = (slab_e > radial) ? slab_e : radial;
        sd_s   = invert_reg ? (~{sd[E-1], sd} + 1'b1) : {sd[E-1], sd};
        if ((&sd_s[E:W-1]) || !(|sd_s[E:W-1]))
        begin
            dist_next = sd_s[W-1:0];
        end
        else if (sd_s[E])
        begin
            dist_next = {1'b1, {(W-1){1'b0}}};
        end
        else
        begin
            dist_next = {1'b0, {(W-1){1'b1}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= pl_valid && rr_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        dist_reg <= dist_next;
    end

    assign done     = done_reg;
    assign distance = dist_reg;

`ifndef NO_ASSERTIONS
    a_done_follows_request : assert property (
        @(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, SQ_OUT + 13)
    ) else $error("result without a matching request");

    a_roots_aligned : assert property (
        @(posedge clk) disable iff (!rst_n)
        pl_valid == rr_valid
    ) else $error("root pipelines out of step");

    a_square_follows_cubic : assert property (
        @(posedge clk) disable iff (!rst_n)
        sq_v_reg |-> $past(in_v_reg, 10)
    ) else $error("square stage valid without cubic input");
`endif

endmodule
